// ===== hdl/dsp_status_report_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the status report parser
// Concurrent assertion wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef DSP_STATUS_REPORT_PARSER_ASSERT_SVH
`define DSP_STATUS_REPORT_PARSER_ASSERT_SVH

// Check while out of reset.
`define DSPSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every edge, reset included.
`define DSPSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/dspsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dspsr_pkg
// Types, codes and sizes shared by the status report parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dspsr_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = $clog2(REPORT_BYTES);
    localparam int HDR_BYTES    = 5;

    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(REPORT_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CLASSIFY = POS_W'(1);
    localparam logic [POS_W-1:0] POS_OPERAND  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_DATA     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_ECHO     = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ECHO_END = POS_W'(13);

    localparam logic [7:0] LEN_OFFSET   = 8'd4;
    localparam logic [7:0] MAX_DATA_LEN = 8'(REPORT_BYTES - 4);

    // header byte 0 values that mark a direct-set reply
    localparam logic [7:0] DIRECT_TAG_A = 8'h01;
    localparam logic [7:0] DIRECT_TAG_B = 8'h02;

    localparam logic [7:0] CMD_BYTE_READ  = 8'h05;
    localparam logic [7:0] CMD_FLOAT_READ = 8'h14;
    localparam logic [7:0] CMD_WRITE_ECHO = 8'h13;
    localparam logic [7:0] FLOAT_HI_ADDR  = 8'h00;

    localparam logic [7:0] OP_VOLUME     = 8'h42;
    localparam logic [7:0] OP_MUTE       = 8'h17;
    localparam logic [7:0] OP_SOURCE     = 8'h34;
    localparam logic [7:0] OP_PRESET     = 8'h25;
    localparam logic [7:0] OP_PRESET_ALT = 8'hAB;

    localparam logic [15:0] ADDR_PRESET     = 16'hFFD8;
    localparam logic [15:0] ADDR_SOURCE     = 16'hFFD9;
    localparam logic [15:0] ADDR_SOURCE_ALT = 16'hFFA9;
    localparam logic [15:0] ADDR_VOLUME     = 16'hFFDA;
    localparam logic [15:0] ADDR_MUTE       = 16'hFFDB;

    localparam logic [7:0] FADDR_IN_LEVEL  = 8'h44;
    localparam logic [7:0] FADDR_OUT_LEVEL = 8'h4A;
    localparam logic [7:0] WADDR_IN_GAIN   = 8'h1A;
    localparam logic [7:0] IN_CHANNELS     = 8'd2;
    localparam logic [7:0] OUT_CHANNELS    = 8'd4;

    typedef enum logic [2:0] {
        RK_NONE,
        RK_DIRECT,
        RK_BYTES,
        RK_FLOATS,
        RK_WRITE
    } rkind_t;

    typedef enum logic [2:0] {
        EV_VOLUME,
        EV_MUTE,
        EV_SOURCE,
        EV_PRESET,
        EV_IN_LEVEL,
        EV_OUT_LEVEL,
        EV_IN_GAIN
    } ev_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sop;
    } in_item_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [1:0]  channel;
        logic [31:0] value;
        logic        changed;
    } event_t;

endpackage

`default_nettype wire

// ===== hdl/dsp_status_report_parser.sv =====
// ----------------------------------------------------------------------------
// dsp_status_report_parser
// Parses status report bytes from an audio DSP into field update events.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    report byte, start-of-report flag
//  m_        out        m_tvalid / m_tready    event kind, channel, value, changed
//  cfg_w     in         cfg_wvalid / cfg_wready always-notify bit
//
//  One byte is taken every cycle while no stalled result holds the flow;
//  a byte passes the input register, the decode logic and the result
//  register, where its event is presented. Reset is synchronous on aresetn
//  low and clears all stored values. A stalled result holds in the result
//  register while one more byte waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsp_status_report_parser
    import dspsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] report_byte
    input  wire logic [0:0]  s_tuser,   // [0] start_of_report
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic [5:0]       m_tuser,   // [2:0] event_kind, [4:3] channel, [5] changed
    input  wire logic        cfg_wvalid,
    output logic             cfg_wready,
    input  wire logic        cfg_wdata
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     ev_hit;
    event_t   ev;
    event_t   ev_out;

    assign s_item.data = s_tdata;
    assign s_item.sop  = s_tuser[0];
    assign cfg_wready  = 1'b1;

    // move the held byte on once the result register is free
    assign advance = item_valid && (!m_tvalid || m_tready);

    dspsr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dspsr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_wvalid && cfg_wready),
        .cfg_notify (cfg_wdata),
        .step       (advance),
        .item       (item),
        .ev_hit     (ev_hit),
        .ev         (ev)
    );

    dspsr_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .hit     (ev_hit),
        .ev_in   (ev),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .ev_out  (ev_out)
    );

    assign m_tdata = ev_out.value;
    assign m_tuser = {ev_out.changed, ev_out.channel, ev_out.kind};

endmodule

`default_nettype wire

// ===== hdl/dspsr_in_stage.sv =====
// ----------------------------------------------------------------------------
// dspsr_in_stage
// Input register: holds one accepted report byte until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dspsr_in_stage
    import dspsr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dspsr_core.sv =====
// ----------------------------------------------------------------------------
// dspsr_core
// Report position, header capture, classification and stored values.
// ----------------------------------------------------------------------------
`default_nettype none

module dspsr_core
    import dspsr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_we,
    input  wire logic     cfg_notify,
    input  wire logic     step,
    input  wire in_item_t item,
    output logic          ev_hit,
    output event_t        ev
);

    logic             notify_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    rkind_t           kind_reg, kind_next;
    logic [7:0]       hdr_reg  [HDR_BYTES];
    logic [7:0]       hdr_next [HDR_BYTES];
    logic [23:0]      fa_reg, fa_next;
    logic [7:0]       vol_reg, vol_next;
    logic [7:0]       mute_reg, mute_next;
    logic [7:0]       src_reg, src_next;
    logic [7:0]       pre_reg, pre_next;
    logic [31:0]      in_lvl_reg  [2];
    logic [31:0]      in_lvl_next [2];
    logic [31:0]      out_lvl_reg  [4];
    logic [31:0]      out_lvl_next [4];
    logic [31:0]      gain_reg  [2];
    logic [31:0]      gain_next [2];

    logic [POS_W-1:0] p;
    rkind_t           kc;
    logic [7:0]       b;
    logic [7:0]       len8, len_clamp;
    logic [POS_W-1:0] data_off, echo_off;
    logic [15:0]      byte_addr;
    logic [7:0]       float_addr, echo_addr, lvl_diff, out_diff, gain_diff;
    logic             bf_en, wf_en, bf_chg, wf_chg;
    ev_kind_t         bf_kind, wf_kind;
    logic [1:0]       wf_ch;
    logic [7:0]       bf_old;
    logic [31:0]      wf_old, word;
    logic             col_en;
    logic [1:0]       col_k;

    assign b          = item.data;
    assign p          = item.sop ? '0 : pos_reg;
    assign kc         = item.sop ? RK_NONE : kind_reg;
    assign len8       = hdr_reg[0] - LEN_OFFSET;
    assign len_clamp  = (len8 > MAX_DATA_LEN) ? MAX_DATA_LEN : len8;
    assign data_off   = p - POS_DATA;
    assign echo_off   = p - POS_ECHO;
    assign byte_addr  = {hdr_reg[2], hdr_reg[3]} + 16'(data_off);
    assign float_addr = hdr_reg[3] + 8'(data_off[POS_W-1:2]);
    assign echo_addr  = hdr_reg[4] + 8'(echo_off[POS_W-1:2]);
    assign lvl_diff   = float_addr - FADDR_IN_LEVEL;
    assign out_diff   = float_addr - FADDR_OUT_LEVEL;
    assign gain_diff  = echo_addr - WADDR_IN_GAIN;
    assign word       = {b, fa_reg};

    // decode which stored field this byte touches
    always_comb begin
        kind_next = kc;
        bf_en     = 1'b0;
        bf_kind   = EV_VOLUME;
        wf_en     = 1'b0;
        wf_kind   = EV_IN_LEVEL;
        wf_ch     = 2'd0;
        col_en    = 1'b0;
        col_k     = 2'd0;
        if (p == POS_CLASSIFY) begin
            if ((hdr_reg[0] == DIRECT_TAG_A || hdr_reg[0] == DIRECT_TAG_B)
                    && b != CMD_WRITE_ECHO) begin
                kind_next = RK_DIRECT;
            end else if (b == CMD_BYTE_READ) begin
                kind_next = RK_BYTES;
            end else if (b == CMD_FLOAT_READ) begin
                kind_next = RK_FLOATS;
            end else if (b == CMD_WRITE_ECHO) begin
                kind_next = RK_WRITE;
            end else begin
                kind_next = RK_NONE;
            end
        end else if (p == POS_OPERAND && kc == RK_DIRECT) begin
            kind_next = RK_NONE;
            case (hdr_reg[1]) inside
                OP_VOLUME: begin
                    bf_en   = 1'b1;
                    bf_kind = EV_VOLUME;
                end
                OP_MUTE: begin
                    bf_en   = 1'b1;
                    bf_kind = EV_MUTE;
                end
                OP_SOURCE: begin
                    bf_en   = 1'b1;
                    bf_kind = EV_SOURCE;
                end
                OP_PRESET, OP_PRESET_ALT: begin
                    bf_en   = 1'b1;
                    bf_kind = EV_PRESET;
                end
                default: begin
                end
            endcase
        end else if (p == POS_OPERAND && kc == RK_FLOATS) begin
            if (b != FLOAT_HI_ADDR) begin
                kind_next = RK_NONE;
            end
        end else if (p >= POS_DATA && kc == RK_BYTES) begin
            if (8'(data_off) < len_clamp) begin
                case (byte_addr) inside
                    ADDR_PRESET: begin
                        bf_en   = 1'b1;
                        bf_kind = EV_PRESET;
                    end
                    ADDR_SOURCE, ADDR_SOURCE_ALT: begin
                        bf_en   = 1'b1;
                        bf_kind = EV_SOURCE;
                    end
                    ADDR_VOLUME: begin
                        bf_en   = 1'b1;
                        bf_kind = EV_VOLUME;
                    end
                    ADDR_MUTE: begin
                        bf_en   = 1'b1;
                        bf_kind = EV_MUTE;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (p >= POS_DATA && kc == RK_FLOATS) begin
            // whole words only
            if (len8[1:0] == 2'd0 && 8'(data_off) < len8) begin
                col_k = data_off[1:0];
                if (col_k != 2'd3) begin
                    col_en = 1'b1;
                end else if (lvl_diff < IN_CHANNELS) begin
                    wf_en   = 1'b1;
                    wf_kind = EV_IN_LEVEL;
                    wf_ch   = lvl_diff[1:0];
                end else if (out_diff < OUT_CHANNELS) begin
                    wf_en   = 1'b1;
                    wf_kind = EV_OUT_LEVEL;
                    wf_ch   = out_diff[1:0];
                end
            end
        end else if (p >= POS_ECHO && p < POS_ECHO_END && kc == RK_WRITE) begin
            col_k = echo_off[1:0];
            if (col_k != 2'd3) begin
                col_en = 1'b1;
            end else if (gain_diff < IN_CHANNELS) begin
                wf_en   = 1'b1;
                wf_kind = EV_IN_GAIN;
                wf_ch   = gain_diff[1:0];
            end
        end
        // drop the kind at the last byte; later bytes are ignored
        if (p == POS_LAST) begin
            kind_next = RK_NONE;
        end
    end

    always_comb begin
        case (bf_kind)
            EV_VOLUME: bf_old = vol_reg;
            EV_MUTE:   bf_old = mute_reg;
            EV_SOURCE: bf_old = src_reg;
            default:   bf_old = pre_reg;
        endcase
        case (wf_kind)
            EV_IN_LEVEL:  wf_old = in_lvl_reg[wf_ch[0]];
            EV_OUT_LEVEL: wf_old = out_lvl_reg[wf_ch];
            default:      wf_old = gain_reg[wf_ch[0]];
        endcase
    end

    assign bf_chg = (b != bf_old);
    assign wf_chg = (word != wf_old);

    always_comb begin
        ev_hit     = 1'b0;
        ev.kind    = bf_kind;
        ev.channel = 2'd0;
        ev.value   = {24'd0, b};
        ev.changed = bf_chg;
        if (bf_en) begin
            ev_hit = bf_chg || notify_reg;
        end else if (wf_en) begin
            ev_hit     = (wf_kind != EV_IN_GAIN) || wf_chg || notify_reg;
            ev.kind    = wf_kind;
            ev.channel = wf_ch;
            ev.value   = word;
            ev.changed = wf_chg;
        end
    end

    always_comb begin
        pos_next     = (p == POS_LAST) ? p : p + POS_W'(1);
        hdr_next     = hdr_reg;
        fa_next      = fa_reg;
        vol_next     = vol_reg;
        mute_next    = mute_reg;
        src_next     = src_reg;
        pre_next     = pre_reg;
        in_lvl_next  = in_lvl_reg;
        out_lvl_next = out_lvl_reg;
        gain_next    = gain_reg;
        for (int i = 0; i < HDR_BYTES; i++) begin
            if (p == POS_W'(i)) begin
                hdr_next[i] = b;
            end
        end
        if (col_en) begin
            case (col_k)
                2'd0:    fa_next[7:0]   = b;
                2'd1:    fa_next[15:8]  = b;
                default: fa_next[23:16] = b;
            endcase
        end
        if (bf_en) begin
            case (bf_kind)
                EV_VOLUME: vol_next  = b;
                EV_MUTE:   mute_next = b;
                EV_SOURCE: src_next  = b;
                default:   pre_next  = b;
            endcase
        end
        if (wf_en) begin
            case (wf_kind)
                EV_IN_LEVEL:  in_lvl_next[wf_ch[0]] = word;
                EV_OUT_LEVEL: out_lvl_next[wf_ch]   = word;
                default:      gain_next[wf_ch[0]]   = word;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            notify_reg <= 1'b0;
            pos_reg    <= '0;
            kind_reg   <= RK_NONE;
            fa_reg     <= '0;
            vol_reg    <= '0;
            mute_reg   <= '0;
            src_reg    <= '0;
            pre_reg    <= '0;
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                in_lvl_reg[i] <= '0;
                gain_reg[i]   <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                out_lvl_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                notify_reg <= cfg_notify;
            end
            if (step) begin
                pos_reg     <= pos_next;
                kind_reg    <= kind_next;
                hdr_reg     <= hdr_next;
                fa_reg      <= fa_next;
                vol_reg     <= vol_next;
                mute_reg    <= mute_next;
                src_reg     <= src_next;
                pre_reg     <= pre_next;
                in_lvl_reg  <= in_lvl_next;
                out_lvl_reg <= out_lvl_next;
                gain_reg    <= gain_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dspsr_out_stage.sv =====
// ----------------------------------------------------------------------------
// dspsr_out_stage
// Result register: holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dspsr_out_stage
    import dspsr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   load,
    input  wire logic   hit,
    input  wire event_t ev_in,
    input  wire logic   m_ready,
    output logic        m_valid,
    output event_t      ev_out
);

    logic   valid_reg;
    logic   valid_next;
    event_t ev_reg;

    assign m_valid = valid_reg;
    assign ev_out  = ev_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = hit;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && hit) begin
            ev_reg <= ev_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dspsr_checker.sv =====
// ----------------------------------------------------------------------------
// dspsr_checker
// Port-level checks on the result channel of the status report parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dsp_status_report_parser_assert.svh"

module dspsr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [5:0]  m_tuser
);

    // hold a stalled event
    `DSPSR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled event changed")

    // byte-field events carry a zero-extended byte on channel 0
    `DSPSR_ASSERT(a_byte_ev, m_tvalid && !m_tuser[2] |-> m_tuser[4:3] == 2'd0 && m_tdata[31:8] == 24'd0, "bad byte-field event")

    // input levels and gains only exist for two channels
    `DSPSR_ASSERT(a_in_ch, m_tvalid && m_tuser[2] && !m_tuser[0] |-> !m_tuser[4], "input channel out of range")

    // no event straight after reset
    `DSPSR_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid, "event valid after reset")

endmodule

bind dsp_status_report_parser dspsr_checker u_dspsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Status report parser testbench
// Streams well-formed DSP status reports with random content, truncated
// reports and raw noise into the parser, with random idling on both stream
// sides and a long output stall. A scoreboard predicts every field update
// event and checks the events in order. always_notify is changed only
// between phases, once the parser has gone idle.
// ============================================================================

module testbench;
    import dspsr_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 200;

    typedef enum int {
        SH_DIRECT,
        SH_BYTES,
        SH_FLOATS,
        SH_WRITE,
        SH_NOISE
    } shape_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parser state and queues the events it must emit
    // ------------------------------------------------------------------------
    class status_scoreboard;
        bit          notify;
        bit [5:0]    pos;
        bit [7:0]    hdr [5];
        rkind_t      kind;
        bit [23:0]   partial;
        bit [7:0]    field [4];      // indexed by volume, mute, source, preset
        bit [31:0]   words [3][4];   // input level, output level, input gain
        event_t      pending_events [$];
        int unsigned mismatches;
        int unsigned events_seen;

        function new();
            kind = RK_NONE;
        endfunction

        function void push(ev_kind_t k, bit [1:0] ch, bit [31:0] val, bit chg);
            event_t ev;
            ev.kind    = k;
            ev.channel = ch;
            ev.value   = val;
            ev.changed = chg;
            pending_events.push_back(ev);
        endfunction

        function void byte_update(ev_kind_t k, bit [7:0] b);
            if (b != field[k] || notify)
                push(k, 2'd0, {24'd0, b}, b != field[k]);
            field[k] = b;
        endfunction

        // levels report on every word, gains only on a change or with notify set
        function void word_update(ev_kind_t k, bit [1:0] ch, bit [31:0] w);
            int s;
            s = k - EV_IN_LEVEL;
            if (k != EV_IN_GAIN || w != words[s][ch] || notify)
                push(k, ch, w, w != words[s][ch]);
            words[s][ch] = w;
        endfunction

        // collect the low three bytes, complete the word on the fourth
        function bit gather(bit [5:0] off, bit [7:0] b, output bit [31:0] w);
            w = {b, partial};
            if (off[1:0] == 2'd3)
                return 1'b1;
            partial[8*off[1:0] +: 8] = b;
            return 1'b0;
        endfunction

        function void note_input(bit [7:0] b, bit sop);
            bit [5:0]  p;
            bit [5:0]  off;
            bit [7:0]  len;
            bit [7:0]  addr8;
            bit [7:0]  idx;
            bit [15:0] addr16;
            bit [31:0] w;
            if (sop) begin
                pos  = 6'd0;
                kind = RK_NONE;
            end
            p = pos;
            if (p < 5)
                hdr[p] = b;
            len = hdr[0] - LEN_OFFSET;
            if (p == 6'd1) begin
                if ((hdr[0] == DIRECT_TAG_A || hdr[0] == DIRECT_TAG_B) && b != CMD_WRITE_ECHO)
                    kind = RK_DIRECT;
                else if (b == CMD_BYTE_READ)
                    kind = RK_BYTES;
                else if (b == CMD_FLOAT_READ)
                    kind = RK_FLOATS;
                else if (b == CMD_WRITE_ECHO)
                    kind = RK_WRITE;
                else
                    kind = RK_NONE;
            end else if (p == 6'd2 && kind == RK_DIRECT) begin
                case (hdr[1])
                    OP_VOLUME: byte_update(EV_VOLUME, b);
                    OP_MUTE: byte_update(EV_MUTE, b);
                    OP_SOURCE: byte_update(EV_SOURCE, b);
                    OP_PRESET, OP_PRESET_ALT: byte_update(EV_PRESET, b);
                    default: ;
                endcase
                kind = RK_NONE;
            end else if (p == 6'd2 && kind == RK_FLOATS) begin
                if (b != FLOAT_HI_ADDR)
                    kind = RK_NONE;
            end else if (p >= 6'd4 && kind == RK_BYTES) begin
                off = p - 6'd4;
                if (len > MAX_DATA_LEN)
                    len = MAX_DATA_LEN;
                if ({2'd0, off} < len) begin
                    addr16 = {hdr[2], hdr[3]} + {10'd0, off};
                    case (addr16)
                        ADDR_PRESET: byte_update(EV_PRESET, b);
                        ADDR_SOURCE, ADDR_SOURCE_ALT: byte_update(EV_SOURCE, b);
                        ADDR_VOLUME: byte_update(EV_VOLUME, b);
                        ADDR_MUTE: byte_update(EV_MUTE, b);
                        default: ;
                    endcase
                end
            end else if (p >= 6'd4 && kind == RK_FLOATS) begin
                off = p - 6'd4;
                if (len[1:0] == 2'd0 && {2'd0, off} < len && gather(off, b, w)) begin
                    addr8 = hdr[3] + {4'd0, off[5:2]};
                    idx = addr8 - FADDR_IN_LEVEL;
                    if (idx < IN_CHANNELS) begin
                        word_update(EV_IN_LEVEL, idx[1:0], w);
                    end else begin
                        idx = addr8 - FADDR_OUT_LEVEL;
                        if (idx < OUT_CHANNELS)
                            word_update(EV_OUT_LEVEL, idx[1:0], w);
                    end
                end
            end else if (p >= 6'd5 && p < 6'd13 && kind == RK_WRITE) begin
                off = p - 6'd5;
                if (gather(off, b, w)) begin
                    idx = hdr[4] + {4'd0, off[5:2]} - WADDR_IN_GAIN;
                    if (idx < IN_CHANNELS)
                        word_update(EV_IN_GAIN, idx[1:0], w);
                end
            end
            // hold the position on the last byte until the next start mark
            if (p != POS_LAST)
                pos = p + 6'd1;
            else
                kind = RK_NONE;
        endfunction

        function void check_result(bit [31:0] value, bit [5:0] user);
            event_t ev;
            events_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind %0d ch %0d value %h changed %0b",
                             user[2:0], user[4:3], value, user[5]);
                return;
            end
            ev = pending_events.pop_front();
            if (ev.kind != user[2:0] || ev.channel != user[4:3] ||
                ev.value != value || ev.changed != user[5]) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("event %0d: expected kind %0d ch %0d value %h changed %0b",
                             events_seen, ev.kind, ev.channel, ev.value, ev.changed);
                    $display("          got      kind %0d ch %0d value %h changed %0b",
                             user[2:0], user[4:3], value, user[5]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, stimulus signals
    // ------------------------------------------------------------------------
    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata    = 8'd0;   // [7:0] report_byte
    logic [0:0]  s_tuser    = 1'b0;   // [0] start_of_report
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [31:0] m_tdata;             // [31:0] value
    logic [5:0]  m_tuser;             // [2:0] event_kind, [4:3] channel, [5] changed
    logic        cfg_wvalid = 1'b0;
    logic        cfg_wready;
    logic        cfg_wdata  = 1'b0;

    status_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    bit          rx_hold_req = 1'b0;

    logic [7:0]  rpt [0:79];
    int          rpt_len;
    bit          rpt_start;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    dsp_status_report_parser u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_wdata  (cfg_wdata)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** dsp_status_report_parser: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // ------------------------------------------------------------------------
    // Event sink: random back-pressure plus one long stall on request
    // ------------------------------------------------------------------------
    initial begin : event_sink
        int gap;
        int held;
        @(posedge aresetn);
        forever begin
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
                rx_hold_req = 1'b0;
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 12);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input bit [7:0] d, input bit sop);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= sop;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(d, sop);
        bytes_sent++;
        if ($urandom_range(0, 63) == 0)
            tx_calm = !tx_calm;
        @(negedge aclk);
    endtask

    // stop offering, wait for every expected event, then let the pipeline settle
    task automatic drain(input int tail);
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input bit v);
        cfg_wvalid <= 1'b1;
        cfg_wdata  <= v;
        @(posedge aclk);
        while (!cfg_wready) @(posedge aclk);
        sb.notify = v;
        @(negedge aclk);
        cfg_wvalid <= 1'b0;
    endtask

    // small pools so that repeated values hit the unchanged case
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(1, 3));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'h3F80_0000;
            2: return 32'hBF00_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void build_report(shape_t shape, bit full);
        int         n;
        bit [15:0]  base;
        bit [31:0]  w;
        for (int i = 0; i < 80; i++)
            rpt[i] = pick_byte();
        rpt_start = 1'b1;
        n = $urandom_range(1, 8);
        case (shape)
            SH_DIRECT: begin
                if ($urandom_range(0, 7) == 0)
                    rpt[0] = 8'($urandom);
                else
                    rpt[0] = $urandom_range(0, 1) ? DIRECT_TAG_B : DIRECT_TAG_A;
                case ($urandom_range(0, 5))
                    0: rpt[1] = OP_VOLUME;
                    1: rpt[1] = OP_MUTE;
                    2: rpt[1] = OP_SOURCE;
                    3: rpt[1] = OP_PRESET;
                    4: rpt[1] = OP_PRESET_ALT;
                    default: rpt[1] = 8'($urandom);
                endcase
                rpt_len = 3;
                if ($urandom_range(0, 3) == 0)
                    rpt_len = 3 + $urandom_range(1, 10);
                if (full)
                    rpt_len = REPORT_BYTES;
            end
            SH_BYTES: begin
                rpt[0] = 8'(n) + LEN_OFFSET;
                rpt[1] = CMD_BYTE_READ;
                case ($urandom_range(0, 2))
                    0: base = ADDR_PRESET - 16'($urandom_range(0, 7));
                    1: base = ADDR_SOURCE_ALT - 16'($urandom_range(0, 7));
                    default: base = 16'($urandom);
                endcase
                {rpt[2], rpt[3]} = base;
                rpt_len = 4 + n;
                if (full) begin
                    // lengths that wrap or run past the report end
                    case ($urandom_range(0, 3))
                        0: rpt[0] = 8'h00;
                        1: rpt[0] = 8'h03;
                        2: rpt[0] = 8'hFF;
                        default: rpt[0] = 8'($urandom);
                    endcase
                    rpt_len = REPORT_BYTES;
                end
            end
            SH_FLOATS: begin
                rpt[0] = 8'(4 * n) + LEN_OFFSET;
                rpt[1] = CMD_FLOAT_READ;
                rpt[2] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : FLOAT_HI_ADDR;
                case ($urandom_range(0, 2))
                    0: rpt[3] = FADDR_IN_LEVEL - 8'($urandom_range(0, 3));
                    1: rpt[3] = FADDR_OUT_LEVEL - 8'($urandom_range(0, 5));
                    default: rpt[3] = 8'($urandom);
                endcase
                for (int i = 4; i + 3 < 80; i += 4) begin
                    w = pick_word();
                    {rpt[i+3], rpt[i+2], rpt[i+1], rpt[i]} = w;
                end
                rpt_len = 4 + 4 * n;
                // length not a whole number of words
                if ($urandom_range(0, 7) == 0)
                    rpt[0] = rpt[0] + 8'($urandom_range(1, 3));
                if (full) begin
                    if ($urandom_range(0, 3) == 0)
                        rpt[0] = 8'($urandom);
                    else
                        rpt[0] = 8'(REPORT_BYTES) + LEN_OFFSET;
                    rpt_len = REPORT_BYTES;
                end
            end
            SH_WRITE: begin
                rpt[0] = ($urandom_range(0, 3) == 0) ? DIRECT_TAG_A : 8'($urandom);
                rpt[1] = CMD_WRITE_ECHO;
                case ($urandom_range(0, 3))
                    0: rpt[4] = WADDR_IN_GAIN - 8'd1;
                    1: rpt[4] = WADDR_IN_GAIN;
                    2: rpt[4] = WADDR_IN_GAIN + 8'd1;
                    default: rpt[4] = 8'($urandom);
                endcase
                for (int i = 5; i < 13; i += 4) begin
                    w = pick_word();
                    {rpt[i+3], rpt[i+2], rpt[i+1], rpt[i]} = w;
                end
                rpt_len = 13;
                // cut short by the next start mark
                if ($urandom_range(0, 7) == 0)
                    rpt_len = $urandom_range(6, 12);
                if (full)
                    rpt_len = REPORT_BYTES;
            end
            default: begin
                rpt_start = 1'($urandom_range(0, 1));
                for (int i = 0; i < 80; i++)
                    rpt[i] = 8'($urandom);
                rpt_len = full ? 75 : $urandom_range(1, 20);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [8:0]  opening [0:25];
        int unsigned target;
        int          r;
        shape_t      shape;
        bit          paused;
        opening = '{
            // no start mark after reset: first byte counts as byte 0
            {1'b0, DIRECT_TAG_A}, {1'b0, OP_VOLUME},      {1'b0, 8'h80},
            // same volume again: silent while always_notify is clear
            {1'b1, DIRECT_TAG_B}, {1'b0, OP_VOLUME},      {1'b0, 8'h80},
            {1'b1, DIRECT_TAG_A}, {1'b0, OP_MUTE},        {1'b0, 8'hFF},
            {1'b1, DIRECT_TAG_B}, {1'b0, OP_SOURCE},      {1'b0, 8'h01},
            {1'b1, DIRECT_TAG_A}, {1'b0, OP_PRESET},      {1'b0, 8'h7F},
            {1'b1, DIRECT_TAG_B}, {1'b0, OP_PRESET_ALT},  {1'b0, 8'h00},
            // float read cancelled by a non-zero high address
            {1'b1, 8'h08},        {1'b0, CMD_FLOAT_READ}, {1'b0, 8'h01},
            {1'b1, 8'h05},        {1'b0, CMD_BYTE_READ},  {1'b0, 8'hFF},
            {1'b0, 8'hDA},        {1'b0, 8'h33}
        };
        paused = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        cfg_write(1'b0);

        foreach (opening[i])
            send_byte(opening[i][7:0], opening[i][8]);
        drain(TAIL_CYCLES);

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(ph[0] ? 1'b0 : 1'b1);
            // stall the output while the input keeps offering bytes
            if (ph == 1)
                rx_hold_req = 1'b1;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    shape = SH_DIRECT;
                else if (r < 45)
                    shape = SH_BYTES;
                else if (r < 70)
                    shape = SH_FLOATS;
                else if (r < 85)
                    shape = SH_WRITE;
                else
                    shape = SH_NOISE;
                build_report(shape, $urandom_range(0, 9) == 0);
                for (int i = 0; i < rpt_len; i++)
                    send_byte(rpt[i], rpt_start && i == 0);
                if (ph == 2 && !paused && bytes_sent + 100 >= target) begin
                    paused = 1'b1;
                    drain(0);
                end
            end
            drain(TAIL_CYCLES);
        end

        $display("Covered %0d report bytes and %0d events, always_notify 0 and 1,",
                 bytes_sent, sb.events_seen);
        $display("with random idling, a %0d-cycle output stall and idle drains.",
                 HOLD_CYCLES);
        if (sb.pending_events.size() != 0)
            $display("%0d expected events never arrived", sb.pending_events.size());
        if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
            $display("** dsp_status_report_parser: PASSED **");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("** dsp_status_report_parser: FAILED **");
        end
        $finish;
    end

endmodule
